### src/tlpq_pkg.sv
// Shared types and constants for the two-level process queue.
// Used by the cell chain, the top level and the port checker.
package tlpq_pkg;

  localparam int KIND_W   = 2;
  localparam int PID_W    = 16;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD = 2'd0,
    KIND_RUN = 2'd1,
    KIND_END = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INS_PREF,
    OP_INS_COMMON,
    OP_POP,
    OP_ROTATE
  } cell_op_t;

  // Occupancy flags that a cell shows to its neighbors
  typedef struct packed {
    logic valid;
    logic pref;
  } cell_flags_t;

endpackage

### src/tlpq_cell.sv
// One slot of the queue chain: valid bit, queue flag and process ID.
// Depends on tlpq_pkg for the cell command and flag types.
module tlpq_cell #(
  parameter int ID_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tlpq_pkg::cell_op_t    op,
  input  logic [ID_WIDTH-1:0]   ins_id,
  input  logic [ID_WIDTH-1:0]   head_id,
  input  tlpq_pkg::cell_flags_t left_flags,
  input  logic [ID_WIDTH-1:0]   left_id,
  input  tlpq_pkg::cell_flags_t right_flags,
  input  logic [ID_WIDTH-1:0]   right_id,
  output tlpq_pkg::cell_flags_t flags,
  output logic [ID_WIDTH-1:0]   id
);
  import tlpq_pkg::*;

  logic                valid_r, valid_nxt;
  logic                pref_r, pref_nxt;
  logic [ID_WIDTH-1:0] id_r, id_nxt;

  // Preferred entries sit in front of common ones, head at the chain's left end.
  always_comb begin
    valid_nxt = valid_r;
    pref_nxt  = pref_r;
    id_nxt    = id_r;
    case (op)
      OP_INS_PREF: begin
        if (!(valid_r && pref_r)) begin
          if (left_flags.valid && left_flags.pref) begin
            valid_nxt = 1'b1;
            pref_nxt  = 1'b1;
            id_nxt    = ins_id;
          end else begin
            // make room: shift the common part one place right
            valid_nxt = left_flags.valid;
            pref_nxt  = left_flags.pref;
            id_nxt    = left_id;
          end
        end
      end
      OP_INS_COMMON: begin
        if (!valid_r && left_flags.valid) begin
          valid_nxt = 1'b1;
          pref_nxt  = 1'b0;
          id_nxt    = ins_id;
        end
      end
      OP_POP: begin
        valid_nxt = right_flags.valid;
        pref_nxt  = right_flags.pref;
        id_nxt    = right_id;
      end
      OP_ROTATE: begin
        if (valid_r && !right_flags.valid) begin
          // last occupied slot takes the old head as a common entry
          valid_nxt = 1'b1;
          pref_nxt  = 1'b0;
          id_nxt    = head_id;
        end else begin
          valid_nxt = right_flags.valid;
          pref_nxt  = right_flags.pref;
          id_nxt    = right_id;
        end
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    pref_r <= pref_nxt;
    id_r   <= id_nxt;
  end

  assign flags.valid = valid_r;
  assign flags.pref  = pref_r;
  assign id          = id_r;

endmodule

### src/two_level_process_queue.sv
// Two-level process queue: a chain of DEPTH cells, preferred IDs ahead of common IDs.
// The result is registered and shows in the cycle after the item is accepted.
// Throughput: one item per cycle unless out_ready stalls; cells shift/hold in step.
// Reset clears the cell valid bits, the entry count and the result valid; the
// stored IDs are not cleared and no clearing pass is needed.
// Depends on tlpq_pkg and tlpq_cell.
module two_level_process_queue #(
  parameter int DEPTH    = 16,
  parameter int ID_WIDTH = 16,
  localparam int CNT_W   = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tlpq_pkg::KIND_W-1:0]   in_kind,
  input  logic [tlpq_pkg::PID_W-1:0]    in_process_id,
  input  logic                          in_preferred,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tlpq_pkg::STATUS_W-1:0] out_status,
  output logic [tlpq_pkg::PID_W-1:0]    out_served_id,
  output logic                          out_served_was_preferred,
  output logic [CNT_W-1:0]              out_total_count
);
  import tlpq_pkg::*;

  cell_flags_t         cell_f [DEPTH];
  logic [ID_WIDTH-1:0] cell_id [DEPTH];
  cell_op_t            op;
  logic                accept;
  logic [ID_WIDTH-1:0] ins_id;

  logic [CNT_W-1:0]    total_r, total_nxt;
  logic                out_valid_r;
  status_t             out_status_r, status_nxt;
  logic [PID_W-1:0]    out_id_r, served_nxt;
  logic                out_pref_r, pref_nxt;
  logic [CNT_W-1:0]    out_total_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign ins_id   = ID_WIDTH'(in_process_id);

  always_comb begin
    op         = OP_HOLD;
    status_nxt = ST_DONE;
    served_nxt = '0;
    pref_nxt   = 1'b0;
    total_nxt  = total_r;
    case (kind_t'(in_kind))
      KIND_ADD: begin
        if (total_r == CNT_W'(DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          op         = in_preferred ? OP_INS_PREF : OP_INS_COMMON;
          served_nxt = PID_W'(ins_id);
          pref_nxt   = in_preferred;
          total_nxt  = total_r + CNT_W'(1);
        end
      end
      KIND_RUN, KIND_END: begin
        if (total_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          served_nxt = PID_W'(cell_id[0]);
          pref_nxt   = cell_f[0].pref;
          if (kind_t'(in_kind) == KIND_RUN) begin
            op = OP_ROTATE;
          end else begin
            op        = OP_POP;
            total_nxt = total_r - CNT_W'(1);
          end
        end
      end
      default: begin
        op = OP_HOLD;
      end
    endcase
    // hold the chain while no item is taken
    if (!accept) begin
      op = OP_HOLD;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cell_flags_t         lf, rf;
    logic [ID_WIDTH-1:0] lid, rid;

    if (g == 0) begin : g_first
      // front of the chain looks like an occupied preferred slot
      assign lf.valid = 1'b1;
      assign lf.pref  = 1'b1;
      assign lid      = '0;
    end else begin : g_mid_l
      assign lf  = cell_f[g-1];
      assign lid = cell_id[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign rf.valid = 1'b0;
      assign rf.pref  = 1'b0;
      assign rid      = '0;
    end else begin : g_mid_r
      assign rf  = cell_f[g+1];
      assign rid = cell_id[g+1];
    end

    tlpq_cell #(
      .ID_WIDTH(ID_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .ins_id     (ins_id),
      .head_id    (cell_id[0]),
      .left_flags (lf),
      .left_id    (lid),
      .right_flags(rf),
      .right_id   (rid),
      .flags      (cell_f[g]),
      .id         (cell_id[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        total_r     <= total_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      out_status_r <= status_nxt;
      out_id_r     <= served_nxt;
      out_pref_r   <= pref_nxt;
      out_total_r  <= total_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_status               = out_status_r;
  assign out_served_id            = out_id_r;
  assign out_served_was_preferred = out_pref_r;
  assign out_total_count          = out_total_r;

endmodule

### src/tlpq_chk.sv
// Port-level checker for the two-level process queue, bound to the top level.
// Depends on tlpq_pkg for the status codes.
module tlpq_chk #(
  parameter int DEPTH    = 16,
  localparam int CNT_W   = $clog2(DEPTH + 1)
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tlpq_pkg::STATUS_W-1:0] out_status,
  input logic [tlpq_pkg::PID_W-1:0]    out_served_id,
  input logic                          out_served_was_preferred,
  input logic [CNT_W-1:0]              out_total_count
);
  import tlpq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_served_id) && $stable(out_total_count))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_served_id == '0
      && !out_served_was_preferred)
    else $error("failed request carries an ID");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_total_count == '0)
    else $error("empty status with entries present");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_total_count == CNT_W'(DEPTH))
    else $error("full status below capacity");

endmodule

bind two_level_process_queue tlpq_chk #(
  .DEPTH(DEPTH)
) u_tlpq_chk (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .out_valid               (out_valid),
  .out_ready               (out_ready),
  .out_status              (out_status),
  .out_served_id           (out_served_id),
  .out_served_was_preferred(out_served_was_preferred),
  .out_total_count         (out_total_count)
);

### dv/testbench.sv
// Self-checking testbench for two_level_process_queue: directed table, then random traffic.
// Predicts results from its own model of the preferred and common queues, or from the table.
// Depends on tlpq_pkg and the two_level_process_queue RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpq_pkg::*;

  localparam int DEPTH = 16;
  localparam int ID_W = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_ITEMS = 450;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  id;
    logic             pref;
    logic [CNT_W-1:0] total;
  } reply_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   pid;
    logic              pref;
    bit                typed;
    reply_t            want;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] in_kind = '0;
  logic [PID_W-1:0] in_process_id = '0;
  logic in_preferred = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [PID_W-1:0] out_served_id;
  logic out_served_was_preferred;
  logic [CNT_W-1:0] out_total_count;

  // model of the two queues, front = head
  logic [ID_W-1:0] pref_ids[$];
  logic [ID_W-1:0] common_ids[$];
  reply_t pending_replies[$];
  request_t directed_rows[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int errors = 0;
  int idle_cycles = 0;
  int n_add = 0, n_run = 0, n_end = 0, n_unused = 0, n_full = 0, n_empty = 0;

  two_level_process_queue #(.DEPTH(DEPTH), .ID_WIDTH(ID_W)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_process_id(in_process_id),
    .in_preferred(in_preferred),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_served_id(out_served_id),
    .out_served_was_preferred(out_served_was_preferred),
    .out_total_count(out_total_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Serve one request against the queue model and return the reply it gives.
  function automatic reply_t queue_request(logic [KIND_W-1:0] kind, logic [ID_W-1:0] pid,
                                           logic pref);
    reply_t r;
    int total;
    r = '0;
    r.status = ST_DONE;
    total = pref_ids.size() + common_ids.size();
    case (kind)
      KIND_ADD: begin
        if (total >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (pref) pref_ids.push_back(pid);
          else common_ids.push_back(pid);
          r.id = pid;
          r.pref = pref;
        end
      end
      KIND_RUN, KIND_END: begin
        if (total == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (pref_ids.size() != 0) begin
            r.id = pref_ids.pop_front();
            r.pref = 1'b1;
          end else begin
            r.id = common_ids.pop_front();
          end
          // run demotes the head to the tail of the common queue
          if (kind == KIND_RUN) common_ids.push_back(r.id);
        end
      end
      default: ;
    endcase
    r.total = CNT_W'(pref_ids.size() + common_ids.size());
    return r;
  endfunction

  function automatic reply_t make_reply(status_t s, logic [ID_W-1:0] id, logic p,
                                        logic [CNT_W-1:0] t);
    reply_t r;
    r.status = s;
    r.id = id;
    r.pref = p;
    r.total = t;
    return r;
  endfunction

  function automatic void table_row(logic [KIND_W-1:0] kind, logic [ID_W-1:0] pid, logic pref,
                                    bit typed, reply_t want);
    request_t r;
    r.kind = kind;
    r.pid = pid;
    r.pref = pref;
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endfunction

  function automatic request_t random_request(int add_pct);
    request_t r;
    int roll;
    roll = $urandom_range(99);
    r.typed = 1'b0;
    r.want = '0;
    r.pid = ID_W'($urandom);
    r.pref = 1'($urandom_range(1));
    if (roll < 3) r.kind = KIND_UNUSED;
    else if (roll < add_pct) r.kind = KIND_ADD;
    else if ($urandom_range(1) == 1) r.kind = KIND_RUN;
    else r.kind = KIND_END;
    return r;
  endfunction

  // Present one item from a falling edge, wait for the handshake, record its reply.
  task automatic offer(request_t r);
    reply_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      do begin
        in_valid <= 1'b0;
        @(negedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_kind <= r.kind;
    in_process_id <= r.pid;
    in_preferred <= r.pref;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = queue_request(r.kind, r.pid, r.pref);
    pending_replies.push_back(r.typed ? r.want : predicted);
    case (r.kind)
      KIND_ADD: n_add++;
      KIND_RUN: n_run++;
      KIND_END: n_end++;
      default: n_unused++;
    endcase
    if (predicted.status == ST_FULL) n_full++;
    if (predicted.status == ST_EMPTY) n_empty++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_replies.size() != 0);
  endtask

  task automatic random_traffic(int n);
    request_t r;
    int sent;
    int add_pct;
    sent = 0;
    add_pct = 50;
    while (sent < n) begin
      // swing between filling and draining so both full and empty get hit
      if (sent % 32 == 0) begin
        case ($urandom_range(2))
          0: add_pct = 15;
          1: add_pct = 50;
          default: add_pct = 85;
        endcase
      end
      r = random_request(add_pct);
      offer(r);
      if (r.kind != KIND_UNUSED) sent++;
    end
  endtask

  task automatic check_field(string name, logic [ID_W-1:0] want_v, logic [ID_W-1:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual status %0d id %0h", $time,
                 out_status, out_served_id);
      end else begin
        want = pending_replies.pop_front();
        check_field("status", ID_W'(want.status), ID_W'(out_status));
        check_field("served_id", want.id, out_served_id);
        check_field("served_was_preferred", ID_W'(want.pref), ID_W'(out_served_was_preferred));
        check_field("total_count", ID_W'(want.total), ID_W'(out_total_count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // empty block, unused kind, then fill to the limit and overflow
    table_row(KIND_RUN, 16'h0000, 1'b0, 1'b1, make_reply(ST_EMPTY, '0, 1'b0, '0));
    table_row(KIND_END, 16'hFFFF, 1'b1, 1'b1, make_reply(ST_EMPTY, '0, 1'b0, '0));
    table_row(KIND_UNUSED, 16'hFFFF, 1'b1, 1'b1, make_reply(ST_DONE, '0, 1'b0, '0));
    table_row(KIND_ADD, 16'hFFFF, 1'b1, 1'b1, make_reply(ST_DONE, 16'hFFFF, 1'b1, CNT_W'(1)));
    table_row(KIND_ADD, 16'h0000, 1'b0, 1'b1, make_reply(ST_DONE, 16'h0000, 1'b0, CNT_W'(2)));
    table_row(KIND_ADD, 16'h8001, 1'b1, 1'b0, '0);
    table_row(KIND_RUN, 16'h5555, 1'b1, 1'b0, '0);
    table_row(KIND_UNUSED, 16'h1234, 1'b0, 1'b0, '0);
    table_row(KIND_END, 16'hAAAA, 1'b0, 1'b0, '0);
    for (int i = 0; i < 14; i++) begin
      table_row(KIND_ADD, (16'h0001 << i) ^ 16'h00F0, i[0], 1'b0, '0);
    end
    table_row(KIND_ADD, 16'hBEEF, 1'b1, 1'b1, make_reply(ST_FULL, '0, 1'b0, CNT_W'(DEPTH)));
    table_row(KIND_RUN, 16'h0000, 1'b0, 1'b0, '0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) offer(directed_rows[i]);
    random_traffic(PHASE_ITEMS);

    // hold the receiver off while the sender keeps pushing
    drain();
    hold_left = 60;
    random_traffic(40);
    drain();

    send_idle_pct = 84;
    random_traffic(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_stall_pct = 84;
    random_traffic(PHASE_ITEMS);
    send_idle_pct = 23;
    recv_stall_pct = 23;
    random_traffic(PHASE_ITEMS);

    drain();
    repeat (5) @(negedge clk);
    $display("covered %0d add, %0d run, %0d end, %0d unused-kind requests", n_add, n_run,
             n_end, n_unused);
    $display("queue full rejects: %0d, empty reports: %0d, errors: %0d", n_full, n_empty,
             errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### two_level_process_queue.f
src/tlpq_pkg.sv
src/tlpq_cell.sv
src/two_level_process_queue.sv
src/tlpq_chk.sv
dv/testbench.sv
